[rtl/segment_intersection_point_defines.svh]
// Assertion macros for the top-level RTL file.
`ifndef SEGMENT_INTERSECTION_POINT_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_DEFINES_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define SIP_CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define SIP_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sip_pkg.sv]
package sip_pkg;

    localparam int CW    = 24;            // coordinate width
    localparam int DW    = CW + 1;        // coordinate difference
    localparam int MAGW  = CW;            // magnitude of a difference
    localparam int PW    = 2 * DW;        // product of two differences
    localparam int NW    = PW + 1;        // cross product (den, sn, tn)
    localparam int DPW   = NW - 1;        // magnitude of the cross product
    localparam int QW    = MAGW;          // quotient bits, one per divider cell
    localparam int LOW   = DPW / 2;       // low slice of tn in the split multiply
    localparam int HIW   = DPW - LOW;     // high slice of tn
    localparam int MW    = DPW + MAGW;    // dividend width

    localparam int IN_DATA_W  = ((8 * CW + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * CW + 7) / 8) * 8;

    typedef enum logic [1:0] {
        HIT_NONE    = 2'd0,
        HIT_POINT   = 2'd1,
        HIT_OVERLAP = 2'd2
    } hit_kind_t;

    typedef struct packed {
        logic [CW-1:0] ax0;
        logic [CW-1:0] ay0;
        hit_kind_t     par_kind;
        logic [CW-1:0] par_x;
        logic [CW-1:0] par_y;
        logic          neg_x;
        logic          neg_y;
        logic          den_zero;
        logic          in_range;
    } sip_side_t;

    typedef struct packed {
        logic [DPW-1:0] rem_x;
        logic [DPW-1:0] rem_y;
        logic [QW-1:0]  num_x;
        logic [QW-1:0]  num_y;
        logic [QW-1:0]  quo_x;
        logic [QW-1:0]  quo_y;
        logic [DPW-1:0] dp;
        sip_side_t      side;
    } sip_div_t;

endpackage

[rtl/sip_div_cell.sv]
module sip_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              vld_in,
    input  sip_pkg::sip_div_t d_in,
    input  logic              adv_in,
    output logic              adv_out,
    output logic              vld_out,
    output sip_pkg::sip_div_t d_out
);
    import sip_pkg::*;

    logic     vld_reg;
    sip_div_t data_reg;
    sip_div_t data_next;

    // One restoring step for x and y: shift in the next dividend bit,
    // subtract the divisor when it fits.
    always_comb begin
        logic [DPW:0] trial_x;
        logic [DPW:0] trial_y;
        logic         ge_x;
        logic         ge_y;
        trial_x   = {d_in.rem_x, d_in.num_x[QW-1]};
        trial_y   = {d_in.rem_y, d_in.num_y[QW-1]};
        ge_x      = trial_x >= {1'b0, d_in.dp};
        ge_y      = trial_y >= {1'b0, d_in.dp};
        data_next = d_in;
        data_next.rem_x = ge_x ? DPW'(trial_x - {1'b0, d_in.dp}) : trial_x[DPW-1:0];
        data_next.rem_y = ge_y ? DPW'(trial_y - {1'b0, d_in.dp}) : trial_y[DPW-1:0];
        data_next.num_x = {d_in.num_x[QW-2:0], 1'b0};
        data_next.num_y = {d_in.num_y[QW-2:0], 1'b0};
        data_next.quo_x = {d_in.quo_x[QW-2:0], ge_x};
        data_next.quo_y = {d_in.quo_y[QW-2:0], ge_y};
    end

    assign adv_out = !vld_reg || adv_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv_out) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            data_reg <= data_next;
        end
    end

    assign vld_out = vld_reg;
    assign d_out   = data_reg;

endmodule

[rtl/sip_front.sv]
module sip_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sip_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           adv_in,
    output logic                           vld_out,
    output sip_pkg::sip_div_t              d_out
);
    import sip_pkg::*;

    typedef struct packed {
        logic          strict;
        logic [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        logic [DW-1:0] d1x, d1y, d2x, d2y, ox, oy;
    } st1_t;

    typedef struct packed {
        sip_side_t     side;
        logic [PW-1:0] pa, pb, pc, pd, pe, pf;
        logic [MAGW-1:0] mag_x, mag_y;
    } st2_t;

    typedef struct packed {
        sip_side_t       side;
        logic [NW-1:0]   den, sn, tn;
        logic [MAGW-1:0] mag_x, mag_y;
    } st3_t;

    typedef struct packed {
        sip_side_t       side;
        logic [DPW-1:0]  dp;
        logic [NW-1:0]   sn, tn;
        logic [MAGW-1:0] mag_x, mag_y;
    } st4_t;

    typedef struct packed {
        sip_side_t             side;
        logic [DPW-1:0]        dp;
        logic [HIW+MAGW-1:0]   phx, phy;
        logic [LOW+MAGW-1:0]   plx, ply;
    } st5_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6;
    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;
    sip_div_t st6_reg, st6_next;

    // A stage moves when it is empty or its successor moves.
    assign adv6 = !v6_reg || adv_in;
    assign adv5 = !v5_reg || adv6;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_tready = adv1;

    // Unpack and form the direction and offset vectors.
    always_comb begin
        logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        ax0 = s_tdata[0*CW +: CW];
        ay0 = s_tdata[1*CW +: CW];
        ax1 = s_tdata[2*CW +: CW];
        ay1 = s_tdata[3*CW +: CW];
        bx0 = s_tdata[4*CW +: CW];
        by0 = s_tdata[5*CW +: CW];
        bx1 = s_tdata[6*CW +: CW];
        by1 = s_tdata[7*CW +: CW];
        st1_next.strict = s_tuser[0];
        st1_next.ax0 = ax0;
        st1_next.ay0 = ay0;
        st1_next.ax1 = ax1;
        st1_next.ay1 = ay1;
        st1_next.bx0 = bx0;
        st1_next.by0 = by0;
        st1_next.bx1 = bx1;
        st1_next.by1 = by1;
        st1_next.d1x = DW'(ax1) - DW'(ax0);
        st1_next.d1y = DW'(ay1) - DW'(ay0);
        st1_next.d2x = DW'(bx1) - DW'(bx0);
        st1_next.d2y = DW'(by1) - DW'(by0);
        st1_next.ox  = DW'(ax0) - DW'(bx0);
        st1_next.oy  = DW'(ay0) - DW'(by0);
    end

    // Six products, and the whole parallel-case decision.
    always_comb begin
        logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        logic signed [CW-1:0] alx, ahx, aly, ahy, blx, bhx, bly, bhy;
        logic signed [DW-1:0] d1x, d1y, d2x, d2y, ox, oy;
        logic a0s, a1s, boxes;
        ax0 = st1_reg.ax0; ay0 = st1_reg.ay0; ax1 = st1_reg.ax1; ay1 = st1_reg.ay1;
        bx0 = st1_reg.bx0; by0 = st1_reg.by0; bx1 = st1_reg.bx1; by1 = st1_reg.by1;
        d1x = st1_reg.d1x; d1y = st1_reg.d1y; d2x = st1_reg.d2x; d2y = st1_reg.d2y;
        ox  = st1_reg.ox;  oy  = st1_reg.oy;
        alx = (ax0 < ax1) ? ax0 : ax1;
        ahx = (ax0 < ax1) ? ax1 : ax0;
        aly = (ay0 < ay1) ? ay0 : ay1;
        ahy = (ay0 < ay1) ? ay1 : ay0;
        blx = (bx0 < bx1) ? bx0 : bx1;
        bhx = (bx0 < bx1) ? bx1 : bx0;
        bly = (by0 < by1) ? by0 : by1;
        bhy = (by0 < by1) ? by1 : by0;
        a0s = (ax0 == bx0 && ay0 == by0) || (ax0 == bx1 && ay0 == by1);
        a1s = (ax1 == bx0 && ay1 == by0) || (ax1 == bx1 && ay1 == by1);
        boxes = (alx <= bhx) && (ahx >= blx) && (aly <= bhy) && (ahy >= bly);

        st2_next.side          = '0;
        st2_next.side.ax0      = ax0;
        st2_next.side.ay0      = ay0;
        st2_next.side.par_kind = HIT_NONE;
        st2_next.side.neg_x    = d1x[DW-1];
        st2_next.side.neg_y    = d1y[DW-1];
        if (!st1_reg.strict || boxes) begin
            if (a0s) begin
                st2_next.side.par_kind = HIT_POINT;
                st2_next.side.par_x    = ax0;
                st2_next.side.par_y    = ay0;
            end else if (a1s) begin
                st2_next.side.par_kind = HIT_POINT;
                st2_next.side.par_x    = ax1;
                st2_next.side.par_y    = ay1;
            end else if (st1_reg.strict) begin
                st2_next.side.par_kind = HIT_OVERLAP;
            end
        end
        st2_next.pa = PW'(d1x) * PW'(d2y);
        st2_next.pb = PW'(d2x) * PW'(d1y);
        st2_next.pc = PW'(d1x) * PW'(oy);
        st2_next.pd = PW'(d1y) * PW'(ox);
        st2_next.pe = PW'(d2x) * PW'(oy);
        st2_next.pf = PW'(d2y) * PW'(ox);
        st2_next.mag_x = d1x[DW-1] ? MAGW'(-d1x) : d1x[MAGW-1:0];
        st2_next.mag_y = d1y[DW-1] ? MAGW'(-d1y) : d1y[MAGW-1:0];
    end

    // Cross products.
    always_comb begin
        st3_next.side  = st2_reg.side;
        st3_next.den   = NW'($signed(st2_reg.pa)) - NW'($signed(st2_reg.pb));
        st3_next.sn    = NW'($signed(st2_reg.pc)) - NW'($signed(st2_reg.pd));
        st3_next.tn    = NW'($signed(st2_reg.pe)) - NW'($signed(st2_reg.pf));
        st3_next.mag_x = st2_reg.mag_x;
        st3_next.mag_y = st2_reg.mag_y;
    end

    // Fold the sign of den into the numerators.
    always_comb begin
        logic signed [NW-1:0] den;
        logic                 den_neg;
        den     = st3_reg.den;
        den_neg = den[NW-1];
        st4_next.side          = st3_reg.side;
        st4_next.side.den_zero = (den == '0);
        st4_next.dp    = den_neg ? DPW'(-den) : den[DPW-1:0];
        st4_next.sn    = den_neg ? NW'(-$signed(st3_reg.sn)) : st3_reg.sn;
        st4_next.tn    = den_neg ? NW'(-$signed(st3_reg.tn)) : st3_reg.tn;
        st4_next.mag_x = st3_reg.mag_x;
        st4_next.mag_y = st3_reg.mag_y;
    end

    // Range check on s and t; split multiply of tn by the direction.
    always_comb begin
        logic [DPW-1:0] tm;
        tm = st4_reg.tn[DPW-1:0];
        st5_next.side          = st4_reg.side;
        st5_next.side.in_range = !st4_reg.sn[NW-1] && (st4_reg.sn[DPW-1:0] <= st4_reg.dp) &&
                                 !st4_reg.tn[NW-1] && (tm <= st4_reg.dp);
        st5_next.dp  = st4_reg.dp;
        st5_next.phx = tm[DPW-1:LOW] * st4_reg.mag_x;
        st5_next.plx = tm[LOW-1:0] * st4_reg.mag_x;
        st5_next.phy = tm[DPW-1:LOW] * st4_reg.mag_y;
        st5_next.ply = tm[LOW-1:0] * st4_reg.mag_y;
    end

    // Join the partial products and load the divider.
    always_comb begin
        logic [MW-1:0] nx;
        logic [MW-1:0] ny;
        nx = (MW'(st5_reg.phx) << LOW) + MW'(st5_reg.plx);
        ny = (MW'(st5_reg.phy) << LOW) + MW'(st5_reg.ply);
        st6_next.rem_x = nx[MW-1:QW];
        st6_next.rem_y = ny[MW-1:QW];
        st6_next.num_x = nx[QW-1:0];
        st6_next.num_y = ny[QW-1:0];
        st6_next.quo_x = '0;
        st6_next.quo_y = '0;
        st6_next.dp    = st5_reg.dp;
        st6_next.side  = st5_reg.side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) st1_reg <= st1_next;
        if (adv2) st2_reg <= st2_next;
        if (adv3) st3_reg <= st3_next;
        if (adv4) st4_reg <= st4_next;
        if (adv5) st5_reg <= st5_next;
        if (adv6) st6_reg <= st6_next;
    end

    assign vld_out = v6_reg;
    assign d_out   = st6_reg;

endmodule

[rtl/segment_intersection_point.sv]
// Channel | Dir | tdata (low bit up)                          | tuser
// s_      | in  | a_start_x a_start_y a_end_x a_end_y         | strict_mode
//         |     | b_start_x b_start_y b_end_x b_end_y (24 ea) |
// m_      | out | hit_x hit_y (24 each)                       | hit_kind
//
// One transaction per cycle sustained while m_tready holds; six front stages
// (differences, products, cross products, sign fold, split multiply, dividend),
// one divider cell per quotient bit (24), then the output register.
// The divider chain retires one quotient bit per cell, which sets the depth.
// Reset clears only the valid bits; payload registers hold whatever they had.
// Every stage advances when empty or when its successor advances, so bubbles
// collapse under an m_tready stall; s_tready follows that ready chain.
`include "segment_intersection_point_defines.svh"

module segment_intersection_point (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sip_pkg::IN_DATA_W-1:0]   s_tdata,   // ax0 ay0 ax1 ay1 bx0 by0 bx1 by1
    input  logic [0:0]                      s_tuser,   // strict_mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sip_pkg::OUT_DATA_W-1:0]  m_tdata,   // hit_x hit_y
    output logic [1:0]                      m_tuser    // hit_kind
);
    import sip_pkg::*;

    sip_div_t  chain_d   [QW+1];
    logic      chain_v   [QW+1];
    logic      chain_adv [QW+1];

    logic          out_vld_reg;
    hit_kind_t     kind_reg, kind_next;
    logic [CW-1:0] hx_reg, hx_next;
    logic [CW-1:0] hy_reg, hy_next;
    logic          out_adv;
    sip_div_t      last;
    logic          kind_legal;

    // Front end: vectors, cross products, range check and dividend.
    sip_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .adv_in   (chain_adv[0]),
        .vld_out  (chain_v[0]),
        .d_out    (chain_d[0])
    );

    // Divider chain: each cell settles one quotient bit for x and for y.
    for (genvar k = 0; k < QW; k++) begin : g_cell
        sip_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .vld_in  (chain_v[k]),
            .d_in    (chain_d[k]),
            .adv_in  (chain_adv[k+1]),
            .adv_out (chain_adv[k]),
            .vld_out (chain_v[k+1]),
            .d_out   (chain_d[k+1])
        );
    end

    assign out_adv        = !out_vld_reg || m_tready;
    assign chain_adv[QW]  = out_adv;
    assign last           = chain_d[QW];

    // Pick the result: parallel pairs take the front-end kind and, on a point hit,
    // the shared endpoint; else a_start plus signed quotient if s and t are in range.
    always_comb begin
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        qx = last.side.neg_x ? CW'(~last.quo_x + 1'b1) : last.quo_x;
        qy = last.side.neg_y ? CW'(~last.quo_y + 1'b1) : last.quo_y;
        kind_next = HIT_NONE;
        hx_next   = '0;
        hy_next   = '0;
        if (last.side.den_zero) begin
            kind_next = last.side.par_kind;
            if (last.side.par_kind == HIT_POINT) begin
                hx_next = last.side.par_x;
                hy_next = last.side.par_y;
            end
        end else if (last.side.in_range) begin
            kind_next = HIT_POINT;
            hx_next   = last.side.ax0 + qx;
            hy_next   = last.side.ay0 + qy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= chain_v[QW];
        end
    end

    // Hold the result until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (out_adv) begin
            kind_reg <= kind_next;
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = OUT_DATA_W'({hy_reg, hx_reg});

    assign kind_legal = (m_tuser == HIT_NONE) || (m_tuser == HIT_POINT) ||
                        (m_tuser == HIT_OVERLAP);

    `SIP_CHK_IMPLY(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
    `SIP_CHK_IMPLY(a_kind_legal, m_tvalid, kind_legal, "illegal hit kind")
    `SIP_CHK_IMPLY(a_point_only_on_hit, m_tvalid && m_tuser != HIT_POINT, m_tdata == '0, "stray point")
    `SIP_CHK_NEXT(a_stall_holds_front, !s_tready && chain_v[0], chain_v[0], "front result lost in stall")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import sip_pkg::*;

    localparam int NUM_RANDOM = 1800;
    localparam int LATENCY    = 31;

    // One segment pair as it travels on the input channel.
    typedef struct {
        logic                 strict_mode;
        logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    // One intersection result as it leaves on the output channel.
    typedef struct {
        hit_kind_t            kind;
        logic signed [CW-1:0] x, y;
    } hit_t;

    // Scoreboard: predicts the hit for each accepted pair and checks results in order.
    class hit_scoreboard;
        hit_t pending_hits[$];
        int   errors;
        int   checked;
        int   kind_count[3];

        function automatic longint lo(longint a, longint b);
            return a < b ? a : b;
        endfunction

        function automatic longint hi(longint a, longint b);
            return a < b ? b : a;
        endfunction

        function automatic hit_t predict_hit(seg_pair_t p);
            hit_t h;
            longint d1x, d1y, d2x, d2y, ox, oy;
            logic signed [127:0] den, sn, tn, qx, qy;
            logic a0_shared, a1_shared, boxes;
            h.kind = HIT_NONE;
            h.x = '0;
            h.y = '0;
            d1x = longint'(p.ax1) - longint'(p.ax0);
            d1y = longint'(p.ay1) - longint'(p.ay0);
            d2x = longint'(p.bx1) - longint'(p.bx0);
            d2y = longint'(p.by1) - longint'(p.by0);
            ox  = longint'(p.ax0) - longint'(p.bx0);
            oy  = longint'(p.ay0) - longint'(p.by0);
            den = 128'(d1x) * 128'(d2y) - 128'(d2x) * 128'(d1y);
            if (den == 0) begin
                a0_shared = (p.ax0 == p.bx0 && p.ay0 == p.by0) ||
                            (p.ax0 == p.bx1 && p.ay0 == p.by1);
                a1_shared = (p.ax1 == p.bx0 && p.ay1 == p.by0) ||
                            (p.ax1 == p.bx1 && p.ay1 == p.by1);
                boxes = lo(p.ax0, p.ax1) <= hi(p.bx0, p.bx1) &&
                        hi(p.ax0, p.ax1) >= lo(p.bx0, p.bx1) &&
                        lo(p.ay0, p.ay1) <= hi(p.by0, p.by1) &&
                        hi(p.ay0, p.ay1) >= lo(p.by0, p.by1);
                if (!p.strict_mode || boxes) begin
                    if (a0_shared) begin
                        h.kind = HIT_POINT; h.x = p.ax0; h.y = p.ay0;
                    end else if (a1_shared) begin
                        h.kind = HIT_POINT; h.x = p.ax1; h.y = p.ay1;
                    end else if (p.strict_mode) begin
                        h.kind = HIT_OVERLAP;
                    end
                end
            end else begin
                sn = 128'(d1x) * 128'(oy) - 128'(d1y) * 128'(ox);
                tn = 128'(d2x) * 128'(oy) - 128'(d2y) * 128'(ox);
                // fold the sign of den into the numerators
                if (den < 0) begin
                    den = -den; sn = -sn; tn = -tn;
                end
                if (sn >= 0 && sn <= den && tn >= 0 && tn <= den) begin
                    // SystemVerilog signed division truncates toward zero
                    qx = (tn * 128'(d1x)) / den;
                    qy = (tn * 128'(d1y)) / den;
                    h.kind = HIT_POINT;
                    h.x = CW'(longint'(p.ax0) + longint'(qx));
                    h.y = CW'(longint'(p.ay0) + longint'(qy));
                end
            end
            return h;
        endfunction

        function void note_pair(seg_pair_t p);
            pending_hits.push_back(predict_hit(p));
        endfunction

        function void check_hit(hit_t got);
            hit_t want;
            if (pending_hits.size() == 0) begin
                $error("result with no pair outstanding: kind=%0d x=%0d y=%0d",
                       got.kind, got.x, got.y);
                errors++;
                return;
            end
            want = pending_hits.pop_front();
            checked++;
            if (int'(want.kind) < 3) kind_count[want.kind]++;
            if (got.kind !== want.kind) begin
                $error("hit_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.x !== want.x) begin
                $error("hit_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("hit_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // ax0 ay0 ax1 ay1 bx0 by0 bx1 by1
    logic [0:0]            s_tuser;   // strict_mode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // hit_x hit_y
    logic [1:0]            m_tuser;   // hit_kind

    hit_scoreboard hits;
    bit            quiet_phase;   // no idling on either side near the end
    bit            stim_done;

    segment_intersection_point dut (.*);

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // Hand one pair to the block; hold it until the transaction completes.
    task automatic send_pair(seg_pair_t p);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= p.strict_mode;
        s_tdata  <= {p.by1, p.bx1, p.by0, p.bx0, p.ay1, p.ax1, p.ay0, p.ax0};
        do @(posedge aclk); while (!s_tready);
        hits.note_pair(p);
    endtask

    // Drop valid and hold off until every outstanding result has drained.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (hits.pending_hits.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CW'($urandom);
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Build a random pair, often shaped into one of the interesting geometric cases.
    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        logic signed [CW-1:0] dx, dy;
        int k;
        p.strict_mode = 1'($urandom_range(0, 1));
        p.ax0 = rand_coord(); p.ay0 = rand_coord();
        p.ax1 = rand_coord(); p.ay1 = rand_coord();
        p.bx0 = rand_coord(); p.by0 = rand_coord();
        p.bx1 = rand_coord(); p.by1 = rand_coord();
        dx = CW'($signed($urandom_range(0, 20)) - 10);
        dy = CW'($signed($urandom_range(0, 20)) - 10);
        case ($urandom_range(0, 7))
            0: begin  // collinear along one direction
                k = $urandom_range(0, 4);
                p.ax1 = CW'(p.ax0 + dx * 3); p.ay1 = CW'(p.ay0 + dy * 3);
                p.bx0 = CW'(p.ax0 + dx * k); p.by0 = CW'(p.ay0 + dy * k);
                p.bx1 = CW'(p.ax0 + dx * ($urandom_range(0, 6) - 1));
                p.by1 = CW'(p.ay0 + dy * ($urandom_range(0, 6) - 1));
                if ($urandom_range(0, 1)) p.by1 = CW'(p.ay0 + dy * (k + 1));
            end
            1: begin  // shared endpoint, random orientation
                if ($urandom_range(0, 1)) begin
                    p.bx0 = p.ax1; p.by0 = p.ay1;
                end else begin
                    p.bx1 = p.ax0; p.by1 = p.ay0;
                end
            end
            2: begin  // zero-length segment A, B sometimes starting on it
                p.ax1 = p.ax0; p.ay1 = p.ay0;
                if ($urandom_range(0, 1)) begin
                    p.bx0 = p.ax0; p.by0 = p.ay0;
                end
            end
            3: begin  // crossing pair near the origin, likely hit
                p.ax0 = CW'(-dx * 9);     p.ay0 = CW'(-dy * 5 - 40);
                p.ax1 = CW'(dx * 7 + 3);  p.ay1 = CW'(dy * 6 + 40);
                p.bx0 = CW'(-50 - dy);    p.by0 = dx;
                p.bx1 = CW'(50 + dx);     p.by1 = -dy;
            end
            4: begin  // parallel offset
                p.bx0 = p.ax0 + dy; p.by0 = p.ay0 + dx;
                p.bx1 = p.ax1 + dy; p.by1 = p.ay1 + dx;
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic seg_pair_t make_pair(logic strict_mode, longint ax0, longint ay0,
                                            longint ax1, longint ay1, longint bx0,
                                            longint by0, longint bx1, longint by1);
        seg_pair_t p;
        p.strict_mode = strict_mode;
        p.ax0 = CW'(ax0); p.ay0 = CW'(ay0); p.ax1 = CW'(ax1); p.ay1 = CW'(ay1);
        p.bx0 = CW'(bx0); p.by0 = CW'(by0); p.bx1 = CW'(bx1); p.by1 = CW'(by1);
        return p;
    endfunction

    // Result side: random back-pressure bursts, check each accepted transaction.
    initial begin
        hit_t got;
        int   stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 6) == 0) begin
                stall = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.kind = hit_kind_t'(m_tuser);
                got.x = m_tdata[CW-1:0];
                got.y = m_tdata[2*CW-1:CW];
                hits.check_hit(got);
            end
        end
    end

    // Stimulus: directed corners, a full drain, then randomized pairs with a drain halfway.
    initial begin
        localparam longint MX = 8388607;
        localparam longint MN = -8388608;
        int n;
        seg_pair_t p;
        hits = new();
        quiet_phase = 0;
        stim_done = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Plain crossing at (0,0), strict and lax.
        send_pair(make_pair(0, -256, -256, 256, 256, -256, 256, 256, -256));
        send_pair(make_pair(1, -256, -256, 256, 256, -256, 256, 256, -256));
        // Touching at the end of B (s = 1) and at the start of A (t = 0).
        send_pair(make_pair(0, 0, 0, 512, 0, 100, 300, 100, 0));
        send_pair(make_pair(0, 0, 0, 512, 0, 0, 300, 0, -300));
        // Lines cross outside the segments.
        send_pair(make_pair(0, 0, 0, 10, 0, 20, -5, 20, 5));
        // Full-range diagonals crossing, truncation of an odd quotient.
        send_pair(make_pair(0, MN, MN, MX, MX, MN, MX, MX, MN));
        send_pair(make_pair(1, MX, MN, MN, MX, MN, MN, MX, MX));
        send_pair(make_pair(0, 0, 0, 3, 7, 0, 5, 5, 0));
        send_pair(make_pair(0, 1, 0, -3, -7, -2, 5, 5, -1));
        // Collinear overlap without shared endpoint: strict vs lax.
        send_pair(make_pair(1, 0, 0, 10, 0, 5, 0, 20, 0));
        send_pair(make_pair(0, 0, 0, 10, 0, 5, 0, 20, 0));
        // Parallel disjoint boxes in strict mode.
        send_pair(make_pair(1, 0, 0, 10, 0, 0, 5, 10, 5));
        // Shared endpoints: a_start matches b_end, a_end matches b_start.
        send_pair(make_pair(0, 3, 3, 9, 9, 6, 6, 3, 3));
        send_pair(make_pair(1, 3, 3, 9, 9, 9, 9, 20, 20));
        // Shared endpoint but disjoint boxes cannot happen; far collinear strict.
        send_pair(make_pair(1, 0, 0, 1, 1, 5, 5, 9, 9));
        // Zero-length segments: same point, distinct points, on a segment.
        send_pair(make_pair(0, 7, 7, 7, 7, 7, 7, 7, 7));
        send_pair(make_pair(1, 7, 7, 7, 7, 8, 8, 8, 8));
        send_pair(make_pair(1, 5, 0, 5, 0, 0, 0, 10, 0));
        // Extremes on every coordinate, then all bits toggled between -1 and 0.
        send_pair(make_pair(1, MX, MX, MX, MX, MN, MN, MN, MN));
        send_pair(make_pair(0, MN, MX, MX, MN, MN, MX, MX, MN));
        send_pair(make_pair(1, -1, -1, -1, 0, 0, -1, -1, -1));
        drain_results();

        n = 0;
        while (n < NUM_RANDOM) begin
            if (n == NUM_RANDOM - 150) quiet_phase = 1;
            if (n == NUM_RANDOM / 2) drain_results();
            p = rand_pair();
            send_pair(p);
            n++;
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Closing: wait for the pipeline to drain, then report.
    initial begin
        wait (stim_done);
        while (hits.pending_hits.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("checked %0d results: %0d none, %0d point, %0d overlap",
                 hits.checked, hits.kind_count[0], hits.kind_count[1],
                 hits.kind_count[2]);
        $display("strict and lax modes, crossings, collinear, degenerate, extremes");
        if (hits.errors == 0 && hits.pending_hits.size() == 0) begin
            $display("** segment_intersection_point: PASSED **");
        end else begin
            $display("** segment_intersection_point: FAILED **");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5ms;
        $display("** segment_intersection_point: FAILED **");
        $finish;
    end

endmodule
